FILE: rtl/core/sfwb_pkg.sv
// ----------------------------------------------------------------------------
// sfwb_pkg
// Shared codes, widths and types of the sequenced frame window buffer.
// ----------------------------------------------------------------------------
package sfwb_pkg;

  localparam int SEQ_W   = 33;
  localparam int IDX_W   = 32;
  localparam int TIME_W  = 64;
  localparam int DELAY_W = 6;
  localparam int TMO_W   = 32;
  localparam int KIND_W  = 3;
  localparam int OP_W    = 2;
  localparam int REG_W   = 2;
  localparam int CFG_W   = 32;
  localparam int LEFT_W  = 4;

  localparam logic [OP_W-1:0] OP_INGEST = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESTARTED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEARED    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOT_PRIMED = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SHORT      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_WINDOW     = 3'd6;

  localparam logic [REG_W-1:0] REG_PLAYBACK_DELAY = 2'd0;
  localparam logic [REG_W-1:0] REG_LONG_HORIZON   = 2'd1;
  localparam logic [REG_W-1:0] REG_FRESH_TIMEOUT  = 2'd2;

  localparam logic [DELAY_W-1:0] DELAY_RESET   = 6'd9;
  localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 32'd100000;

  // window length minus one
  localparam logic [LEFT_W-1:0] SHORT_LAST = 4'd3;
  localparam logic [LEFT_W-1:0] LONG_LAST  = 4'd9;

  typedef enum logic [1:0] {
    CMD_INGEST,
    CMD_READ,
    CMD_CLEAR
  } cmd_t;

  typedef struct packed {
    logic             primed;
    logic             fresh;
    logic [SEQ_W-1:0] oldest;
    logic [SEQ_W-1:0] newest;
    logic [SEQ_W-1:0] cursor;
  } stat_t;

endpackage

FILE: rtl/core/sfwb_ram.sv
// ----------------------------------------------------------------------------
// sfwb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfwb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/sfwb_front.sv
// ----------------------------------------------------------------------------
// sfwb_front
// Input side: takes items, decodes the op code into a command and pushes
// it into the command queue. Unused op codes are taken and discarded.
// ----------------------------------------------------------------------------
module sfwb_front #(
  parameter int PAYLOAD_BITS = 64,
  localparam int ENTRY_W = 2 + sfwb_pkg::IDX_W + PAYLOAD_BITS + sfwb_pkg::TIME_W
) (
  input  logic                        s_valid,
  output logic                        s_ready,
  input  logic [sfwb_pkg::OP_W-1:0]   op,
  input  logic [sfwb_pkg::IDX_W-1:0]  seq_index,
  input  logic [PAYLOAD_BITS-1:0]     frame_payload,
  input  logic [sfwb_pkg::TIME_W-1:0] now_time,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [ENTRY_W-1:0]          q_entry
);
  import sfwb_pkg::*;

  cmd_t cmd;
  logic op_ok;

  always_comb begin
    case (op)
      OP_INGEST: begin
        cmd   = CMD_INGEST;
        op_ok = 1'b1;
      end
      OP_READ: begin
        cmd   = CMD_READ;
        op_ok = 1'b1;
      end
      OP_CLEAR: begin
        cmd   = CMD_CLEAR;
        op_ok = 1'b1;
      end
      default: begin
        cmd   = CMD_INGEST;
        op_ok = 1'b0;
      end
    endcase
  end

  assign s_ready = !q_full;
  assign q_push  = s_valid && !q_full && op_ok;
  assign q_entry = {cmd, seq_index, frame_payload, now_time};

endmodule

FILE: rtl/core/sfwb_queue.sv
// ----------------------------------------------------------------------------
// sfwb_queue
// Two-entry command queue between the input side and the executor.
// ----------------------------------------------------------------------------
module sfwb_queue #(
  parameter int WIDTH = 162
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == 2'd2);
  assign valid   = (fill != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: rtl/core/sfwb_back.sv
// ----------------------------------------------------------------------------
// sfwb_back
// Executor: holds the buffer state and registers, runs one command at a
// time and drives the result register. Window frames stream out of the ring.
// ----------------------------------------------------------------------------
module sfwb_back #(
  parameter int RING_DEPTH   = 64,
  parameter int PAYLOAD_BITS = 64,
  localparam int SLOT_W  = $clog2(RING_DEPTH),
  localparam int CNT_W   = $clog2(RING_DEPTH + 1),
  localparam int ENTRY_W = 2 + sfwb_pkg::IDX_W + PAYLOAD_BITS + sfwb_pkg::TIME_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [sfwb_pkg::REG_W-1:0]  cfg_index,
  input  logic [sfwb_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        q_valid,
  input  logic [ENTRY_W-1:0]          q_data,
  output logic                        q_pop,
  output logic                        m_valid,
  input  logic                        m_ready,
  output logic [sfwb_pkg::KIND_W-1:0] m_kind,
  output logic [sfwb_pkg::IDX_W-1:0]  m_index,
  output logic [PAYLOAD_BITS-1:0]     m_payload,
  output logic                        m_last,
  output logic [CNT_W-1:0]            m_count,
  output sfwb_pkg::stat_t             m_stat
);
  import sfwb_pkg::*;

  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = CNT_W + DELAY_W;
  localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(RING_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_STAT,
    S_POST,
    S_EMIT
  } state_t;

  state_t state;

  logic [DELAY_W-1:0] delay;
  logic               horizon;
  logic [TMO_W-1:0]   timeout;

  logic              primed;
  logic [SEQ_W-1:0]  oldest;
  logic [SEQ_W-1:0]  newest;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] head;
  logic [TIME_W-1:0] progress;

  cmd_t                    c_cmd;
  logic [IDX_W-1:0]        c_idx;
  logic [PAYLOAD_BITS-1:0] c_pay;
  logic [TIME_W-1:0]       c_now;
  logic [KIND_W-1:0]       c_kind;

  logic              st_fresh;
  logic [SEQ_W-1:0]  st_cursor;
  logic [SLOT_W-1:0] win_slot;
  logic [IDX_W-1:0]  win_idx;
  logic [LEFT_W-1:0] win_left;

  cmd_t                    q_cmd;
  logic [IDX_W-1:0]        q_idx;
  logic [PAYLOAD_BITS-1:0] q_pay;
  logic [TIME_W-1:0]       q_now;

  logic                    out_free;
  logic                    out_load;
  logic                    dup;
  logic                    gap;
  logic [SLOT_W-1:0]       base_head;
  logic [CNT_W-1:0]        base_count;
  logic [SUM_W-1:0]        ins_sum;
  logic [SLOT_W-1:0]       ins_slot;
  logic [SLOT_W-1:0]       head_inc;
  logic [LEFT_W-1:0]       win_last;
  logic                    win_ok;
  logic [SUM_W-1:0]        start_sum;
  logic [SLOT_W-1:0]       start_slot;
  logic [SLOT_W-1:0]       slot_inc;
  logic [TIME_W-1:0]       elapsed;
  logic                    fresh_calc;
  logic [SEQ_W-1:0]        cursor_calc;
  logic                    wr_en;
  logic                    rd_en;
  logic [SLOT_W-1:0]       rd_addr;
  logic [PAYLOAD_BITS-1:0] rd_data;

  assign q_now = q_data[TIME_W-1:0];
  assign q_pay = q_data[TIME_W +: PAYLOAD_BITS];
  assign q_idx = q_data[TIME_W+PAYLOAD_BITS +: IDX_W];
  assign q_cmd = cmd_t'(q_data[ENTRY_W-1 -: 2]);

  assign out_free = !m_valid || m_ready;
  assign out_load = out_free && (((state == S_POST) && (c_kind != KIND_WINDOW)) ||
                                 (state == S_EMIT));
  assign q_pop    = (state == S_IDLE) && q_valid;

  // ingest classification and slot
  assign dup        = primed && (c_idx <= newest[IDX_W-1:0]);
  assign gap        = primed && ({1'b0, c_idx} != (newest + SEQ_W'(1)));
  assign base_head  = gap ? '0 : head;
  assign base_count = gap ? '0 : count;
  assign ins_sum    = SUM_W'(base_head) + SUM_W'(base_count);
  assign ins_slot   = (ins_sum >= DEPTH_S) ? SLOT_W'(ins_sum - DEPTH_S) : SLOT_W'(ins_sum);
  assign head_inc   = (base_head == SLOT_LAST) ? '0 : base_head + SLOT_W'(1);

  // While primed the run is dense: count = newest - oldest + 1, so the
  // cursor offset from the oldest frame is count - 1 - delay.
  assign win_last   = horizon ? LONG_LAST : SHORT_LAST;
  assign win_ok     = (CMP_W'(delay) >= CMP_W'(win_last)) && (CMP_W'(delay) < CMP_W'(count));
  assign start_sum  = SUM_W'(head) + (SUM_W'(count) - SUM_W'(1) - SUM_W'(delay));
  assign start_slot = (start_sum >= DEPTH_S) ? SLOT_W'(start_sum - DEPTH_S)
                                             : SLOT_W'(start_sum);
  assign slot_inc   = (win_slot == SLOT_LAST) ? '0 : win_slot + SLOT_W'(1);

  assign elapsed     = c_now - progress;
  assign fresh_calc  = primed && (progress != '0) && (elapsed < TIME_W'(timeout));
  assign cursor_calc = primed ? (newest - SEQ_W'(delay)) : '1;

  assign wr_en   = (state == S_EXEC) && (c_cmd == CMD_INGEST) && !dup;
  assign rd_en   = ((state == S_POST) && (c_kind == KIND_WINDOW)) ||
                   ((state == S_EMIT) && out_free && (win_left != '0));
  assign rd_addr = (state == S_POST) ? win_slot : slot_inc;

  sfwb_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ins_slot),
    .wr_data (c_pay),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_valid  <= 1'b0;
      delay    <= DELAY_RESET;
      horizon  <= 1'b0;
      timeout  <= TIMEOUT_RESET;
      primed   <= 1'b0;
      oldest   <= '1;
      newest   <= '1;
      count    <= '0;
      head     <= '0;
      progress <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_PLAYBACK_DELAY: delay   <= cfg_data[DELAY_W-1:0];
          REG_LONG_HORIZON:   horizon <= cfg_data[0];
          REG_FRESH_TIMEOUT:  timeout <= cfg_data[TMO_W-1:0];
          default: ;
        endcase
      end

      if (m_ready && !out_load) begin
        m_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (q_valid) begin
            c_cmd <= q_cmd;
            c_idx <= q_idx;
            c_pay <= q_pay;
            c_now <= q_now;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          case (c_cmd)
            CMD_INGEST: begin
              if (dup) begin
                c_kind <= KIND_DROPPED;
              end else begin
                c_kind   <= gap ? KIND_RESTARTED : KIND_ACCEPTED;
                primed   <= 1'b1;
                newest   <= {1'b0, c_idx};
                progress <= c_now;
                if (base_count == DEPTH_C) begin
                  // ring full: evict the oldest frame
                  head   <= head_inc;
                  oldest <= oldest + SEQ_W'(1);
                end else begin
                  head  <= base_head;
                  count <= base_count + CNT_W'(1);
                  if (!primed || gap) begin
                    oldest <= {1'b0, c_idx};
                  end
                end
              end
            end
            CMD_READ: begin
              if (!primed) begin
                c_kind <= KIND_NOT_PRIMED;
              end else if (win_ok) begin
                c_kind <= KIND_WINDOW;
              end else begin
                c_kind <= KIND_SHORT;
              end
            end
            CMD_CLEAR: begin
              c_kind   <= KIND_CLEARED;
              primed   <= 1'b0;
              oldest   <= '1;
              newest   <= '1;
              count    <= '0;
              head     <= '0;
              progress <= '0;
            end
            default: ;
          endcase
          state <= S_STAT;
        end

        S_STAT: begin
          st_fresh  <= fresh_calc;
          st_cursor <= cursor_calc;
          win_slot  <= start_slot;
          win_idx   <= cursor_calc[IDX_W-1:0];
          win_left  <= win_last;
          state     <= S_POST;
        end

        S_POST: begin
          if (c_kind == KIND_WINDOW) begin
            state <= S_EMIT;
          end else if (out_free) begin
            m_valid       <= 1'b1;
            m_kind        <= c_kind;
            m_index       <= '0;
            m_payload     <= '0;
            m_last        <= 1'b1;
            m_count       <= count;
            m_stat.primed <= primed;
            m_stat.fresh  <= st_fresh;
            m_stat.oldest <= oldest;
            m_stat.newest <= newest;
            m_stat.cursor <= st_cursor;
            state         <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            m_valid       <= 1'b1;
            m_kind        <= KIND_WINDOW;
            m_index       <= win_idx;
            m_payload     <= rd_data;
            m_last        <= (win_left == '0);
            m_count       <= count;
            m_stat.primed <= primed;
            m_stat.fresh  <= st_fresh;
            m_stat.oldest <= oldest;
            m_stat.newest <= newest;
            m_stat.cursor <= st_cursor;
            win_idx       <= win_idx + IDX_W'(1);
            win_slot      <= slot_inc;
            win_left      <= win_left - LEFT_W'(1);
            if (win_left == '0) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/sequenced_frame_window_buffer.sv
// ----------------------------------------------------------------------------
// sequenced_frame_window_buffer
// Playback buffer for numbered frames with sequence check and window read.
// ----------------------------------------------------------------------------
//  channel   direction  signals                                   moves
//  s_*       in         s_tvalid s_tready s_tdata s_tuser         one command item
//  m_*       out        m_tvalid m_tready m_tdata m_tuser m_tlast one result item
//  cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data    one register write
//
//  Ingest, drop, clear and failed reads: one result, from the queue via IDLE,
//  EXEC, STAT and POST to the output register. A window read then streams one
//  frame a cycle from the ring RAM (4 or 10 frames) unless an output stall
//  pauses the ring reads; the executor state machine runs one command at a
//  time. A two-entry queue keeps taking items while it works. rst is synchronous;
//  ring contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module sequenced_frame_window_buffer #(
  parameter int RING_DEPTH   = 64,
  parameter int PAYLOAD_BITS = 64,
  localparam int CNT_W   = $clog2(RING_DEPTH + 1),
  localparam int IN_RAW  = sfwb_pkg::IDX_W + PAYLOAD_BITS + sfwb_pkg::TIME_W,
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW = sfwb_pkg::IDX_W + PAYLOAD_BITS + 2 + CNT_W + 3 * sfwb_pkg::SEQ_W,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // seq_index, frame_payload, now_time
  input  logic [IN_W-1:0]             s_tdata,
  // op
  input  logic [sfwb_pkg::OP_W-1:0]   s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // out_index, out_payload, is_primed, is_fresh, stored_count,
  // oldest_index, newest_index, cursor_index
  output logic [OUT_W-1:0]            m_tdata,
  // kind
  output logic [sfwb_pkg::KIND_W-1:0] m_tuser,
  output logic                        m_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sfwb_pkg::REG_W-1:0]  cfg_index,
  input  logic [sfwb_pkg::CFG_W-1:0]  cfg_data
);
  import sfwb_pkg::*;

  localparam int ENTRY_W = 2 + IDX_W + PAYLOAD_BITS + TIME_W;

  logic                    q_full;
  logic                    q_push;
  logic [ENTRY_W-1:0]      q_entry;
  logic                    q_valid;
  logic                    q_pop;
  logic [ENTRY_W-1:0]      q_data;
  logic [IDX_W-1:0]        r_index;
  logic [PAYLOAD_BITS-1:0] r_payload;
  logic [CNT_W-1:0]        r_count;
  stat_t                   r_stat;

  assign cfg_ready = 1'b1;

  sfwb_front #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .s_valid       (s_tvalid),
    .s_ready       (s_tready),
    .op            (s_tuser),
    .seq_index     (s_tdata[IDX_W-1:0]),
    .frame_payload (s_tdata[IDX_W +: PAYLOAD_BITS]),
    .now_time      (s_tdata[IDX_W+PAYLOAD_BITS +: TIME_W]),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  sfwb_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_entry),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_data)
  );

  sfwb_back #(
    .RING_DEPTH   (RING_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_kind    (m_tuser),
    .m_index   (r_index),
    .m_payload (r_payload),
    .m_last    (m_tlast),
    .m_count   (r_count),
    .m_stat    (r_stat)
  );

  assign m_tdata = OUT_W'({r_stat.cursor, r_stat.newest, r_stat.oldest, r_count,
                           r_stat.fresh, r_stat.primed, r_payload, r_index});

endmodule

FILE: rtl/core/sfwb_checker.sv
// ----------------------------------------------------------------------------
// sfwb_checker
// Port-level checks of the frame window buffer, bound to the top level.
// ----------------------------------------------------------------------------
module sfwb_checker #(
  parameter int RING_DEPTH   = 64,
  parameter int PAYLOAD_BITS = 64,
  localparam int CNT_W   = $clog2(RING_DEPTH + 1),
  localparam int OUT_RAW = sfwb_pkg::IDX_W + PAYLOAD_BITS + 2 + CNT_W + 3 * sfwb_pkg::SEQ_W,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [OUT_W-1:0]            m_tdata,
  input logic [sfwb_pkg::KIND_W-1:0] m_tuser,
  input logic                        m_tlast
);
  import sfwb_pkg::*;

  localparam int ST_LO  = IDX_W + PAYLOAD_BITS;
  localparam int CNT_LO = ST_LO + 2;
  localparam int OLD_LO = CNT_LO + CNT_W;
  localparam int NEW_LO = OLD_LO + SEQ_W;
  localparam int CUR_LO = NEW_LO + SEQ_W;

  logic [IDX_W-1:0]        o_index;
  logic [PAYLOAD_BITS-1:0] o_payload;
  logic                    o_primed;
  logic                    o_fresh;
  logic [CNT_W-1:0]        o_count;
  logic [SEQ_W-1:0]        o_oldest;
  logic [SEQ_W-1:0]        o_newest;
  logic [SEQ_W-1:0]        o_cursor;

  assign o_index   = m_tdata[IDX_W-1:0];
  assign o_payload = m_tdata[IDX_W +: PAYLOAD_BITS];
  assign o_primed  = m_tdata[ST_LO];
  assign o_fresh   = m_tdata[ST_LO+1];
  assign o_count   = m_tdata[CNT_LO +: CNT_W];
  assign o_oldest  = m_tdata[OLD_LO +: SEQ_W];
  assign o_newest  = m_tdata[NEW_LO +: SEQ_W];
  assign o_cursor  = m_tdata[CUR_LO +: SEQ_W];

  // status results are single, marked last, with no frame data
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_WINDOW) |-> m_tlast && (o_index == '0) && (o_payload == '0))
    else $error("status result not last or carries frame data");

  // an empty buffer shows the empty markers and is never fresh
  a_unprimed_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !o_primed |-> (o_count == '0) && !o_fresh && (o_cursor == '1) &&
                              (o_oldest == '1) && (o_newest == '1))
    else $error("unprimed result with stale ring status");

  // a restart leaves exactly the arriving frame in the ring
  a_restart_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_RESTARTED) |->
      o_primed && (o_count == CNT_W'(1)) && (o_oldest == o_newest))
    else $error("restart did not reset the run");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind sequenced_frame_window_buffer sfwb_checker #(
  .RING_DEPTH   (RING_DEPTH),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_sfwb_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sequenced frame window buffer: commands go in
// through a stall-prone stream driver and a software copy of the ring works
// out the status and window items, which the monitor checks field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RING         = 64;
  localparam int IN_W         = 160;
  localparam int OUT_W        = 208;
  localparam int DRAIN_CYCLES = 30;
  localparam int WATCH_LIMIT  = 4000;
  localparam logic [sfwb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint IDX_MAX  = 64'h0000_0000_FFFF_FFFF;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] idx;
    logic [63:0] pay;
    logic [63:0] now;
  } command_s;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] idx;
    logic [63:0] pay;
    logic        last;
    logic        primed;
    logic        fresh;
    logic [6:0]  count;
    logic [32:0] oldest;
    logic [32:0] newest;
    logic [32:0] cursor;
  } frame_result_s;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic [1:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [2:0]       m_tuser;
  logic             m_tlast;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  sequenced_frame_window_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // mirror of the buffer: registers and ring
  logic [5:0]  delay_r = sfwb_pkg::DELAY_RESET;
  logic        long_r  = 1'b0;
  logic [31:0] tmo_r   = sfwb_pkg::TIMEOUT_RESET;
  bit          primed  = 1'b0;
  longint      oldest_seq = -1;
  longint      newest_seq = -1;
  int          held = 0;
  int          head = 0;
  logic [63:0] progress = '0;
  logic [63:0] ring [RING];

  command_s      pending_q [$];
  frame_result_s owed_q [$];
  int            err_cnt = 0;
  int            result_no = 0;
  bit            calm = 1'b0;

  // stimulus generator view of the newest index, -1 when empty
  longint      gen_last = -1;
  logic [63:0] gen_clock = '0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %0s at result %0d: got %h want %h", what, result_no, got, want);
    err_cnt++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_result(input logic [2:0] kind, input logic [31:0] idx,
                             input logic [63:0] pay, input logic last, input logic [63:0] now);
    frame_result_s r;
    logic [63:0] age;
    longint cur;
    age = now - progress;
    cur = primed ? newest_seq - longint'(delay_r) : -1;
    r.kind   = kind;
    r.idx    = idx;
    r.pay    = pay;
    r.last   = last;
    r.primed = primed;
    r.fresh  = primed && progress != 0 && age < {32'd0, tmo_r};
    r.count  = held[6:0];
    r.oldest = oldest_seq[32:0];
    r.newest = newest_seq[32:0];
    r.cursor = cur[32:0];
    owed_q.insert(owed_q.size(), r);
  endtask

  task automatic apply_command(input command_s c);
    longint idx;
    longint n;
    longint cur;
    longint off;
    longint at;
    logic [2:0] kind;
    idx = longint'(c.idx);
    case (c.op)
      sfwb_pkg::OP_INGEST: begin
        if (primed && idx <= newest_seq) begin
          push_result(sfwb_pkg::KIND_DROPPED, '0, '0, 1'b1, c.now);
        end else begin
          kind = sfwb_pkg::KIND_ACCEPTED;
          if (primed && idx != newest_seq + 1) begin
            primed = 1'b0;
            held = 0;
            head = 0;
            kind = sfwb_pkg::KIND_RESTARTED;
          end
          ring[6'((head + held) % RING)] = c.pay;
          held++;
          if (!primed) begin
            oldest_seq = idx;
            primed = 1'b1;
          end
          newest_seq = idx;
          // ring full: evict the oldest frame
          if (held > RING) begin
            head = (head + 1) % RING;
            held--;
            oldest_seq++;
          end
          progress = c.now;
          push_result(kind, '0, '0, 1'b1, c.now);
        end
      end
      sfwb_pkg::OP_READ: begin
        n = long_r ? 10 : 4;
        if (!primed) begin
          push_result(sfwb_pkg::KIND_NOT_PRIMED, '0, '0, 1'b1, c.now);
        end else begin
          cur = newest_seq - longint'(delay_r);
          off = cur - oldest_seq;
          if (cur < oldest_seq || cur + n - 1 > newest_seq || off + n > held) begin
            push_result(sfwb_pkg::KIND_SHORT, '0, '0, 1'b1, c.now);
          end else begin
            for (int f = 0; f < n; f++) begin
              at = cur + f;
              push_result(sfwb_pkg::KIND_WINDOW, at[31:0], ring[6'((head + off + f) % RING)],
                          f == n - 1, c.now);
            end
          end
        end
      end
      sfwb_pkg::OP_CLEAR: begin
        primed = 1'b0;
        oldest_seq = -1;
        newest_seq = -1;
        held = 0;
        head = 0;
        progress = '0;
        push_result(sfwb_pkg::KIND_CLEARED, '0, '0, 1'b1, c.now);
      end
      default: ;
    endcase
  endtask

  // ---- driver ----
  bit       send_on = 1'b0;
  int       send_gap = 0;
  command_s send_item = '{default: '0};

  always @(posedge clk) begin
    if (rst) begin
      send_on = 1'b0;
      send_gap = 0;
    end else begin
      if (send_on && s_tready) begin
        apply_command(send_item);
        send_on = 1'b0;
      end
      if (!send_on) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() != 0) begin
          send_item = pending_q[0];
          pending_q.delete(0);
          send_on = 1'b1;
          send_gap = pick_gap();
        end
      end
    end
    s_tvalid <= send_on;
    s_tdata  <= {send_item.now, send_item.pay, send_item.idx};
    s_tuser  <= send_item.op;
  end

  // ---- monitor ----
  int stall_left = 0;
  bit take_next = 1'b0;

  task automatic check_result();
    frame_result_s w;
    if (owed_q.size() == 0) begin
      report("unowed item kind", 64'(m_tuser), '0);
      return;
    end
    w = owed_q[0];
    owed_q.delete(0);
    if (m_tuser !== w.kind)
      report("kind", 64'(m_tuser), 64'(w.kind));
    if (m_tdata[31:0] !== w.idx)
      report("index", 64'(m_tdata[31:0]), 64'(w.idx));
    if (m_tdata[95:32] !== w.pay)
      report("payload", m_tdata[95:32], w.pay);
    if (m_tlast !== w.last)
      report("last", 64'(m_tlast), 64'(w.last));
    if (m_tdata[96] !== w.primed)
      report("primed", 64'(m_tdata[96]), 64'(w.primed));
    if (m_tdata[97] !== w.fresh)
      report("fresh", 64'(m_tdata[97]), 64'(w.fresh));
    if (m_tdata[104:98] !== w.count)
      report("count", 64'(m_tdata[104:98]), 64'(w.count));
    if (m_tdata[137:105] !== w.oldest)
      report("oldest", 64'(m_tdata[137:105]), 64'(w.oldest));
    if (m_tdata[170:138] !== w.newest)
      report("newest", 64'(m_tdata[170:138]), 64'(w.newest));
    if (m_tdata[203:171] !== w.cursor)
      report("cursor", 64'(m_tdata[203:171]), 64'(w.cursor));
    result_no++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_result();
      if (stall_left > 0) begin
        stall_left--;
        take_next = 1'b0;
      end else begin
        take_next = 1'b1;
        stall_left = pick_gap();
      end
    end
    m_tready <= take_next;
  end

  // ---- watchdog: cycles without any handshake ----
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- stimulus ----
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      sfwb_pkg::REG_PLAYBACK_DELAY: delay_r = value[5:0];
      sfwb_pkg::REG_LONG_HORIZON:   long_r  = value[0];
      sfwb_pkg::REG_FRESH_TIMEOUT:  tmo_r   = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || send_on || owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_cmd(input logic [1:0] op, input logic [31:0] idx,
                           input logic [63:0] pay, input logic [63:0] now);
    command_s c;
    c.op = op;
    c.idx = idx;
    c.pay = pay;
    c.now = now;
    pending_q.insert(pending_q.size(), c);
  endtask

  function automatic longint fresh_base();
    case ($urandom_range(0, 3))
      0: return longint'($urandom_range(0, 100));
      1: return IDX_MAX - longint'($urandom_range(0, 150));
      default: return longint'($urandom);
    endcase
  endfunction

  // steady: in-order ingests and reads (a drop or clear at index wrap), so the ring fills up
  function automatic command_s rand_cmd(input bit steady);
    command_s c;
    int pick;
    longint v;
    c.op  = sfwb_pkg::OP_INGEST;
    c.pay = {$urandom, $urandom};
    gen_clock += 64'($urandom_range(0, 3000));
    c.now = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : gen_clock;
    c.idx = $urandom;
    pick = $urandom_range(0, 99);
    if (steady) pick = (pick < 80) ? 0 : 70;
    if (pick < 62) begin
      if (gen_last == IDX_MAX) begin
        // index would wrap: either show the drop or start over
        if ($urandom_range(0, 1) == 0) c.idx = '0;
        else begin
          c.op = sfwb_pkg::OP_CLEAR;
          gen_last = -1;
        end
      end else begin
        v = (gen_last < 0) ? fresh_base() : gen_last + 1;
        c.idx = v[31:0];
        gen_last = v;
      end
    end else if (pick < 82) begin
      c.op = sfwb_pkg::OP_READ;
    end else if (pick < 88) begin
      if (gen_last < 0) begin
        v = fresh_base();
        gen_last = v;
      end else if ($urandom_range(0, 3) == 0) begin
        v = longint'($urandom_range(0, gen_last[31:0]));
      end else begin
        v = (gen_last >= 3) ? gen_last - longint'($urandom_range(0, 3)) : gen_last;
      end
      c.idx = v[31:0];
    end else if (pick < 94) begin
      v = gen_last + longint'($urandom_range(2, 40));
      if (gen_last < 0 || v > IDX_MAX) v = fresh_base();
      c.idx = v[31:0];
      if (v > gen_last) gen_last = v;
    end else if (pick < 97) begin
      c.op = sfwb_pkg::OP_CLEAR;
      gen_last = -1;
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  initial begin
    logic [31:0] tmo;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset register values
    queue_cmd(sfwb_pkg::OP_READ, '0, '0, '0);
    queue_cmd(sfwb_pkg::OP_CLEAR, '0, '0, 64'd10);
    queue_cmd(OP_UNUSED, '1, '1, '1);
    queue_cmd(sfwb_pkg::OP_INGEST, 32'd0, '0, '0);
    queue_cmd(sfwb_pkg::OP_INGEST, 32'd1, '1, 64'd50);
    queue_cmd(sfwb_pkg::OP_INGEST, 32'd1, {$urandom, $urandom}, 64'd60);
    queue_cmd(sfwb_pkg::OP_INGEST, 32'd0, {$urandom, $urandom}, 64'd70);
    queue_cmd(sfwb_pkg::OP_READ, '0, '0, 64'd200000);
    queue_cmd(sfwb_pkg::OP_INGEST, 32'd5, {$urandom, $urandom}, 64'd200100);
    for (int i = 6; i <= 14; i++)
      queue_cmd(sfwb_pkg::OP_INGEST, i, {$urandom, $urandom}, 64'd200100 + 64'(i * 1000));
    queue_cmd(sfwb_pkg::OP_READ, '0, '0, 64'd250000);
    queue_cmd(sfwb_pkg::OP_INGEST, 32'hFFFF_FFFF, '1, '1);
    // wrap to zero counts as backwards
    queue_cmd(sfwb_pkg::OP_INGEST, 32'd0, '0, 64'd5);
    queue_cmd(sfwb_pkg::OP_READ, '0, '0, '1);
    queue_cmd(sfwb_pkg::OP_CLEAR, '0, '0, '1);
    queue_cmd(sfwb_pkg::OP_READ, '0, '0, 64'd1);
    wait_idle();

    // deepest window, fill and evict the ring
    write_reg(sfwb_pkg::REG_PLAYBACK_DELAY, 32'd63);
    write_reg(sfwb_pkg::REG_LONG_HORIZON, 32'd1);
    write_reg(sfwb_pkg::REG_FRESH_TIMEOUT, 32'hFFFF_FFFF);
    gen_last = -1;
    gen_clock = 64'd1000;
    for (int i = 0; i < 90; i++) pending_q.insert(pending_q.size(), rand_cmd(1'b1));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: tmo = '0;
        1: tmo = $urandom_range(500, 5000);
        default: tmo = 32'hFFFF_FFFF;
      endcase
      write_reg(sfwb_pkg::REG_PLAYBACK_DELAY, (ph == 0) ? 32'd0 : $urandom_range(1, 12));
      write_reg(sfwb_pkg::REG_LONG_HORIZON, ph % 2);
      write_reg(sfwb_pkg::REG_FRESH_TIMEOUT, tmo);
      calm = (ph % 2 == 1);
      for (int i = 0; i < 20; i++) pending_q.insert(pending_q.size(), rand_cmd(i < 8));
      wait_idle();
    end

    if (owed_q.size() != 0) report("items never delivered", 64'(owed_q.size()), '0);
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sfwb_pkg.sv
rtl/core/sfwb_ram.sv
rtl/core/sfwb_front.sv
rtl/core/sfwb_queue.sv
rtl/core/sfwb_back.sv
rtl/core/sequenced_frame_window_buffer.sv
rtl/core/sfwb_checker.sv
sim/tb_top.sv
